### rtl/wsfm_pkg.sv
// ----------------------------------------------------------------------------
// wsfm_pkg
// Types and constants shared by the wheel status fault monitor and its
// channel interfaces.
// ----------------------------------------------------------------------------
package wsfm_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned TORQUE_W    = 16;
  localparam int unsigned RUNBYTE_W   = 8;
  localparam int unsigned LIMIT_W     = 15;
  localparam int unsigned PERSIST_W   = 8;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TOTAL_OUT_W = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [LIMIT_W-1:0]   STUCK_SPEED_LIMIT_RST  = LIMIT_W'(1000);
  localparam logic [PERSIST_W-1:0] STUCK_PERSIST_RST      = PERSIST_W'(3);
  localparam logic [LIMIT_W-1:0]   TORQUE_LIMIT_RST       = LIMIT_W'(1000);
  localparam logic [PERSIST_W-1:0] TORQUE_PERSIST_RST     = PERSIST_W'(3);
  localparam logic [PERIOD_W-1:0]  CRC_REPORT_RST         = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0]  MALFORMED_REPORT_RST   = PERIOD_W'(10);

  typedef enum logic [REQ_W-1:0] {
    REQ_REPLY     = 2'd0,
    REQ_CRC       = 2'd1,
    REQ_MALFORMED = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STUCK_SPEED_LIMIT      = 3'd0,
    CFG_STUCK_PERSIST_COUNT    = 3'd1,
    CFG_TORQUE_LIMIT           = 3'd2,
    CFG_TORQUE_PERSIST_COUNT   = 3'd3,
    CFG_CRC_REPORT_EVERY       = 3'd4,
    CFG_MALFORMED_REPORT_EVERY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [SPEED_W-1:0]  speed_rpm;
    logic signed [TORQUE_W-1:0] torque_raw;
    logic [RUNBYTE_W-1:0]    running_byte;
  } status_req_t;

  typedef struct packed {
    logic                   stuck_flag;
    logic                   torque_high_flag;
    logic                   crc_event;
    logic                   malformed_event;
    logic [TOTAL_OUT_W-1:0] crc_error_total;
    logic [TOTAL_OUT_W-1:0] malformed_total;
  } fault_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

### rtl/wsfm_stream_if.sv
// ----------------------------------------------------------------------------
// wsfm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface wsfm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/wheel_status_fault_monitor.sv
// ----------------------------------------------------------------------------
// wheel_status_fault_monitor
// An input item passes the input register, then the result register; the
// result is valid once registered. One item per cycle while the output is
// not stalled. The input side keeps taking items while a result waits, as
// long as the input register can move on. Reset clears all runs, totals,
// phases and valids, and loads the default thresholds and periods.
// ----------------------------------------------------------------------------
module wheel_status_fault_monitor #(
  parameter int unsigned COUNT_WIDTH = wsfm_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsfm_stream_if.sink   req_i,
  wsfm_stream_if.source rsp_o,
  wsfm_stream_if.sink   cfg_i
);
  import wsfm_pkg::*;

  // configuration
  logic [LIMIT_W-1:0]   stuck_limit_q;
  logic [PERSIST_W-1:0] stuck_persist_q;
  logic [LIMIT_W-1:0]   torque_limit_q;
  logic [PERSIST_W-1:0] torque_persist_q;
  logic [PERIOD_W-1:0]  crc_every_q;
  logic [PERIOD_W-1:0]  mal_every_q;
  cfg_wr_t              cfg_wr;

  assign cfg_wr      = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_limit_q    <= STUCK_SPEED_LIMIT_RST;
      stuck_persist_q  <= STUCK_PERSIST_RST;
      torque_limit_q   <= TORQUE_LIMIT_RST;
      torque_persist_q <= TORQUE_PERSIST_RST;
      crc_every_q      <= CRC_REPORT_RST;
      mal_every_q      <= MALFORMED_REPORT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_wr.reg_index))
        CFG_STUCK_SPEED_LIMIT:      stuck_limit_q    <= cfg_wr.wdata[LIMIT_W-1:0];
        CFG_STUCK_PERSIST_COUNT:    stuck_persist_q  <= cfg_wr.wdata[PERSIST_W-1:0];
        CFG_TORQUE_LIMIT:           torque_limit_q   <= cfg_wr.wdata[LIMIT_W-1:0];
        CFG_TORQUE_PERSIST_COUNT:   torque_persist_q <= cfg_wr.wdata[PERSIST_W-1:0];
        CFG_CRC_REPORT_EVERY:       crc_every_q      <= cfg_wr.wdata;
        CFG_MALFORMED_REPORT_EVERY: mal_every_q      <= cfg_wr.wdata;
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic        in_valid_q;
  status_req_t in_q;
  logic        out_valid_q;
  fault_rsp_t  out_q;
  logic        adv;

  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // decode
  logic                 is_status;
  logic                 is_crc;
  logic                 is_mal;
  logic [SPEED_W-1:0]   aspeed;
  logic [TORQUE_W-1:0]  atorque;
  logic                 stuck_cond;
  logic                 torque_cond;

  assign is_status = (req_type_e'(in_q.req_type) == REQ_REPLY);
  assign is_crc    = (req_type_e'(in_q.req_type) == REQ_CRC);
  assign is_mal    = (req_type_e'(in_q.req_type) == REQ_MALFORMED);

  assign aspeed  = in_q.speed_rpm[SPEED_W-1]
                 ? (SPEED_W'(0) - $unsigned(in_q.speed_rpm)) : $unsigned(in_q.speed_rpm);
  assign atorque = in_q.torque_raw[TORQUE_W-1]
                 ? (TORQUE_W'(0) - $unsigned(in_q.torque_raw)) : $unsigned(in_q.torque_raw);

  assign stuck_cond  = (in_q.running_byte == '0) && (aspeed > SPEED_W'(stuck_limit_q));
  assign torque_cond = atorque > TORQUE_W'(torque_limit_q);

  // persistence runs
  logic [PERSIST_W-1:0] stuck_run_q, stuck_run_d;
  logic [PERSIST_W-1:0] torque_run_q, torque_run_d;
  logic [PERSIST_W:0]   stuck_sum, torque_sum;
  logic                 stuck_hit, torque_hit;

  assign stuck_sum  = {1'b0, stuck_run_q} + (PERSIST_W+1)'(1);
  assign torque_sum = {1'b0, torque_run_q} + (PERSIST_W+1)'(1);
  assign stuck_hit  = stuck_cond && (stuck_sum >= {1'b0, stuck_persist_q});
  assign torque_hit = torque_cond && (torque_sum >= {1'b0, torque_persist_q});

  always_comb begin
    stuck_run_d  = stuck_run_q;
    torque_run_d = torque_run_q;
    if (adv && is_status) begin
      stuck_run_d  = (!stuck_cond || stuck_hit) ? '0 : stuck_sum[PERSIST_W-1:0];
      torque_run_d = (!torque_cond || torque_hit) ? '0 : torque_sum[PERSIST_W-1:0];
    end
  end

  // error totals and reporting periods
  logic [COUNT_WIDTH-1:0] crc_total_q, crc_total_d;
  logic [COUNT_WIDTH-1:0] mal_total_q, mal_total_d;
  logic [PERIOD_W-1:0]    crc_phase_q, crc_phase_d;
  logic [PERIOD_W-1:0]    mal_phase_q, mal_phase_d;
  logic [PERIOD_W:0]      crc_sum, mal_sum;
  logic                   crc_hit, mal_hit;

  assign crc_sum = {1'b0, crc_phase_q} + (PERIOD_W+1)'(1);
  assign mal_sum = {1'b0, mal_phase_q} + (PERIOD_W+1)'(1);
  assign crc_hit = is_crc && (crc_every_q != '0) && (crc_sum >= {1'b0, crc_every_q});
  assign mal_hit = is_mal && (mal_every_q != '0) && (mal_sum >= {1'b0, mal_every_q});

  always_comb begin
    crc_total_d = crc_total_q;
    crc_phase_d = crc_phase_q;
    mal_total_d = mal_total_q;
    mal_phase_d = mal_phase_q;
    if (adv && is_crc) begin
      crc_total_d = crc_total_q + COUNT_WIDTH'(1);
      crc_phase_d = ((crc_every_q == '0) || crc_hit) ? '0 : crc_sum[PERIOD_W-1:0];
    end
    if (adv && is_mal) begin
      mal_total_d = mal_total_q + COUNT_WIDTH'(1);
      mal_phase_d = ((mal_every_q == '0) || mal_hit) ? '0 : mal_sum[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_run_q  <= '0;
      torque_run_q <= '0;
      crc_total_q  <= '0;
      mal_total_q  <= '0;
      crc_phase_q  <= '0;
      mal_phase_q  <= '0;
    end else begin
      stuck_run_q  <= stuck_run_d;
      torque_run_q <= torque_run_d;
      crc_total_q  <= crc_total_d;
      mal_total_q  <= mal_total_d;
      crc_phase_q  <= crc_phase_d;
      mal_phase_q  <= mal_phase_d;
    end
  end

  // result register
  fault_rsp_t out_d;

  always_comb begin
    out_d.stuck_flag       = is_status && stuck_hit;
    out_d.torque_high_flag = is_status && torque_hit;
    out_d.crc_event        = crc_hit;
    out_d.malformed_event  = mal_hit;
    out_d.crc_error_total  = TOTAL_OUT_W'(crc_total_d);
    out_d.malformed_total  = TOTAL_OUT_W'(mal_total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule
